/* hdl/vch_pkg.sv */
// ----------------------------------------------------------------------------
// vch_pkg: shared definitions of the vertex cache simulator
// Default sizes, field widths, stream layouts and shared types.
// ----------------------------------------------------------------------------
package vch_pkg;

    localparam int MAX_VERTICES_DEF = 65536;
    localparam int STAMP_BITS_DEF   = 48;
    localparam int MAX_CACHE_DEF    = 64;

    localparam int VERT_BITS      = 16;
    localparam int VERTS_PER_FACE = 3;
    localparam int CFG_BITS       = 7;
    localparam int FACE_BITS      = 24;
    localparam int MISS_BITS      = 2;

    localparam logic [CFG_BITS-1:0]  CACHE_RESET = 7'd16;
    localparam logic [FACE_BITS-1:0] FACE_MAX    = {FACE_BITS{1'b1}};
    localparam logic [MISS_BITS-1:0] ALL_MISSED  = MISS_BITS'(VERTS_PER_FACE);

    localparam int QUEUE_DEPTH = 4;

    localparam int S_TDATA_BITS = ((VERTS_PER_FACE * VERT_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((MISS_BITS + FACE_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        PH_A = 3'b001,
        PH_B = 3'b010,
        PH_C = 3'b100
    } t_phase;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

/* hdl/vertex_cache_hard_boundaries.sv */
// Throughput: set by the single read port of the stamp memory, which serves one
// vertex probe per cycle while a triangle is queued and the result is not stalled;
// each triangle needs one probe for each of its vertices.
// Reset: synchronous, active low. After reset the stamp memory is swept to zero,
// one slot per cycle; s_axis_tready stays low meanwhile.
// ----------------------------------------------------------------------------
// vertex_cache_hard_boundaries: FIFO vertex cache miss simulator
// Counts vertex cache misses per triangle by per-vertex timestamps and flags
// triangles that start a new hard cluster.
// ----------------------------------------------------------------------------
module vertex_cache_hard_boundaries #(
    parameter int MAX_VERTICES = vch_pkg::MAX_VERTICES_DEF,  // power of two
    parameter int STAMP_BITS   = vch_pkg::STAMP_BITS_DEF,
    parameter int MAX_CACHE    = vch_pkg::MAX_CACHE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel: the cache size register.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vch_pkg::CFG_BITS-1:0]     i_cfg_data,     // cache entries
    // Triangle input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [vch_pkg::S_TDATA_BITS-1:0] s_axis_tdata,   // vertex_a, vertex_b, vertex_c
    input  logic                             s_axis_tuser,   // new_run
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [vch_pkg::M_TDATA_BITS-1:0] m_axis_tdata,   // miss_count, face_index, zeros
    output logic                             m_axis_tuser    // is_boundary
);
    import vch_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int QW = 3 * AW + 1;

    // The front maps each vertex onto a stamp slot and queues the triangle;
    // the back pops it and probes the three slots one after another. A
    // queued entry holds the three slot addresses and the new-run flag.
    t_queue_status q_status;
    logic          q_push;
    logic          q_pop;
    logic [QW-1:0] q_push_data;
    logic [QW-1:0] q_pop_data;
    logic          clearing;

    // The register is a plain flop in the back and takes any write at once.
    assign o_cfg_ready = 1'b1;

    vch_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_clearing    (clearing),
        .i_q_status    (q_status),
        .o_push        (q_push),
        .o_push_data   (q_push_data)
    );

    vch_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_status    (q_status)
    );

    // The back forwards a stamp written in the same cycle as a read of the
    // same slot, so a vertex repeated within a triangle, or across adjacent
    // triangles, always sees its latest stamp.
    vch_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .STAMP_BITS   (STAMP_BITS),
        .MAX_CACHE    (MAX_CACHE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_q_status    (q_status),
        .i_q_data      (q_pop_data),
        .o_pop         (q_pop),
        .o_clearing    (clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* hdl/vch_queue.sv */
// ----------------------------------------------------------------------------
// vch_queue: short triangle queue
// Register-based FIFO that decouples triangle intake from stamp processing.
// ----------------------------------------------------------------------------
module vch_queue #(
    parameter int W     = 49,
    parameter int DEPTH = vch_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [W-1:0]           i_push_data,
    input  logic                   i_pop,
    output logic [W-1:0]           o_pop_data,
    output vch_pkg::t_queue_status o_status
);
    import vch_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_entries [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_entries[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

/* hdl/vch_front.sv */
// ----------------------------------------------------------------------------
// vch_front: triangle intake
// Accepts triangle transactions, maps vertex indices onto stamp slots and
// pushes them into the queue.
// ----------------------------------------------------------------------------
module vch_front #(
    parameter int MAX_VERTICES = vch_pkg::MAX_VERTICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [vch_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                i_clearing,
    input  vch_pkg::t_queue_status              i_q_status,
    output logic                                o_push,
    output logic [3*$clog2(MAX_VERTICES):0]     o_push_data
);
    import vch_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    logic [VERT_BITS-1:0] vertex [VERTS_PER_FACE];
    logic                 r_open;

    // Intake stays closed for the cycle after reset; the stamp clear holds it
    // closed after that.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= 1'b1;
        end
    end

    assign s_axis_tready = r_open && !i_clearing && !i_q_status.full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    // The slot is the vertex index modulo the (power of two) store depth.
    always_comb begin
        for (int k = 0; k < VERTS_PER_FACE; k++) begin
            vertex[k] = s_axis_tdata[k*VERT_BITS +: VERT_BITS];
            o_push_data[k*AW +: AW] = AW'(vertex[k]);
        end
        o_push_data[3*AW] = s_axis_tuser;
    end

endmodule

/* hdl/vch_back.sv */
// ----------------------------------------------------------------------------
// vch_back: stamp store and miss evaluation
// Probes one vertex per cycle against the stamp memory while a triangle is queued and the result
// is not stalled, keeps the running timestamp and face counter and registers one result per triangle.
// ----------------------------------------------------------------------------
module vch_back #(
    parameter int MAX_VERTICES = vch_pkg::MAX_VERTICES_DEF,
    parameter int STAMP_BITS   = vch_pkg::STAMP_BITS_DEF,
    parameter int MAX_CACHE    = vch_pkg::MAX_CACHE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [vch_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  vch_pkg::t_queue_status           i_q_status,
    input  logic [3*$clog2(MAX_VERTICES):0]  i_q_data,
    output logic                             o_pop,
    output logic                             o_clearing,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [vch_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
    output logic                             m_axis_tuser
);
    import vch_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int SW  = STAMP_BITS;
    localparam int CSW = $clog2(MAX_CACHE + 1);
    localparam int PAD = M_TDATA_BITS - MISS_BITS - FACE_BITS;

    function automatic logic [CSW-1:0] clamp_cache(input logic [CFG_BITS-1:0] v);
        logic [CSW-1:0] res;
        if (v == '0) begin
            res = CSW'(1);
        end else if (int'(v) > MAX_CACHE) begin
            res = CSW'(MAX_CACHE);
        end else begin
            res = CSW'(v);
        end
        return res;
    endfunction

    localparam logic [CSW-1:0] CS_RESET = clamp_cache(CACHE_RESET);

    logic [SW-1:0] r_stamp_mem [MAX_VERTICES];
    logic [SW-1:0] r_rd_data;
    logic [SW-1:0] r_fwd_data;
    logic          r_fwd_hit;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_cnt;

    logic [CSW-1:0] r_cs_eff;
    logic [SW-1:0]  r_now;
    logic [FACE_BITS-1:0] r_face;
    logic [MISS_BITS-1:0] r_acc;

    t_phase        r_phase;
    t_phase        n_phase;
    logic [1:0]    iss_idx;
    logic [AW-1:0] iss_addr;
    logic          iss;

    logic          r_c_valid;
    t_phase        r_c_phase;
    logic [AW-1:0] r_c_addr;
    logic          r_c_new_run;

    logic                 c_stall;
    logic                 c_fire;
    logic [SW-1:0]        cs_sw;
    logic [SW-1:0]        adj;
    logic [SW-1:0]        now_eff;
    logic [SW-1:0]        stamp;
    logic [SW-1:0]        age;
    logic                 miss;
    logic [MISS_BITS-1:0] acc_new;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [SW-1:0]        wdata;

    logic                 r_out_valid;
    logic [MISS_BITS-1:0] r_out_miss;
    logic [FACE_BITS-1:0] r_out_face;
    logic                 r_out_bnd;

    // Configuration: the clamped cache size is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_eff <= CS_RESET;
        end else if (i_cfg_valid) begin
            r_cs_eff <= clamp_cache(i_cfg_data);
        end
    end

    // Clearing sweep over the stamp memory, one slot per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == AW'(MAX_VERTICES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_clearing = r_clr_busy;

    // Issue stage: one vertex read per cycle while a triangle is queued and the result is not stalled.
    always_comb begin
        unique case (r_phase)
            PH_A: begin
                iss_idx = 2'd0;
                n_phase = PH_B;
            end
            PH_B: begin
                iss_idx = 2'd1;
                n_phase = PH_C;
            end
            PH_C: begin
                iss_idx = 2'd2;
                n_phase = PH_A;
            end
            default: begin
                iss_idx = 2'd0;
                n_phase = PH_A;
            end
        endcase
        iss_addr = i_q_data[iss_idx*AW +: AW];
    end

    assign c_stall = r_c_valid && (r_c_phase == PH_C) && r_out_valid && !m_axis_tready;
    assign c_fire  = r_c_valid && !c_stall;
    assign iss     = !r_clr_busy && !i_q_status.empty && !c_stall;
    assign o_pop   = iss && (r_phase == PH_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_A;
            r_c_valid <= 1'b0;
            r_c_phase <= PH_A;
        end else begin
            if (iss) begin
                r_phase <= n_phase;
            end
            if (!c_stall) begin
                r_c_valid <= iss;
                r_c_phase <= r_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (iss) begin
            r_c_addr    <= iss_addr;
            r_c_new_run <= i_q_data[3*AW];
            r_fwd_hit   <= c_fire && miss && (r_c_addr == iss_addr);
            r_fwd_data  <= now_eff;
        end
    end

    // Evaluate stage: age test against the stamp read at issue, or the forwarded one.
    always_comb begin
        cs_sw   = SW'(r_cs_eff);
        adj     = (r_c_phase == PH_A && r_c_new_run) ? cs_sw + 1'b1 : '0;
        now_eff = r_now + adj;
        stamp   = r_fwd_hit ? r_fwd_data : r_rd_data;
        age     = now_eff - stamp;
        miss    = (age > cs_sw);
        acc_new = ((r_c_phase == PH_A) ? '0 : r_acc) + MISS_BITS'(miss);
    end

    always_comb begin
        if (r_clr_busy) begin
            we    = 1'b1;
            waddr = r_clr_cnt;
            wdata = '0;
        end else begin
            we    = c_fire && miss;
            waddr = r_c_addr;
            wdata = now_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_stamp_mem[waddr] <= wdata;
        end
        if (iss) begin
            r_rd_data <= r_stamp_mem[iss_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now  <= SW'(CS_RESET) + 1'b1;
            r_face <= '0;
        end else if (c_fire) begin
            r_now <= miss ? now_eff + 1'b1 : now_eff;
            if (r_c_phase == PH_A && r_c_new_run) begin
                r_face <= '0;
            end else if (r_c_phase == PH_C && r_face != FACE_MAX) begin
                r_face <= r_face + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire) begin
            r_acc <= acc_new;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_fire && r_c_phase == PH_C) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire && r_c_phase == PH_C) begin
            r_out_miss <= acc_new;
            r_out_face <= r_face;
            r_out_bnd  <= (r_face == '0) || (acc_new == ALL_MISSED);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD{1'b0}}, r_out_face, r_out_miss};
    assign m_axis_tuser  = r_out_bnd;

endmodule

/* hdl/vch_checker.sv */
// ----------------------------------------------------------------------------
// vch_checker: port-level checks of the vertex cache simulator
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module vch_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [vch_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
    input logic                             m_axis_tuser
);
    import vch_pkg::*;

    // The stamp clear keeps intake closed right after reset.
    a_closed_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("triangle accepted before the stamp clear");

    a_all_miss_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[MISS_BITS-1:0] == ALL_MISSED) |-> m_axis_tuser)
        else $error("triangle with three misses not flagged as boundary");

    a_first_face_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[MISS_BITS +: FACE_BITS] == '0) |-> m_axis_tuser)
        else $error("first triangle of a run not flagged as boundary");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind vertex_cache_hard_boundaries vch_checker u_vch_checker (.*);

/* test/vch_face_checker.sv */
// ----------------------------------------------------------------------------
// vch_face_checker: result checker of the vertex cache miss simulator
// Watches the configuration, triangle and result channels. It keeps its own
// copy of the per-vertex stamps, predicts each triangle's result and compares
// every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module vch_face_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [vch_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [vch_pkg::S_TDATA_BITS-1:0] i_s_tdata,   // vertex_a, vertex_b, vertex_c
    input  logic                             i_s_tuser,   // new_run
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [vch_pkg::M_TDATA_BITS-1:0] i_m_tdata,   // miss_count, face_index, zeros
    input  logic                             i_m_tuser,   // is_boundary
    output int                               o_errors,
    output int                               o_outstanding
);
    import vch_pkg::*;

    localparam int STAMP_W   = STAMP_BITS_DEF;
    localparam int PAD_BITS  = M_TDATA_BITS - MISS_BITS - FACE_BITS;

    typedef struct packed {
        logic [MISS_BITS-1:0] misses;
        logic                 boundary;
        logic [FACE_BITS-1:0] face;
    } t_face_verdict;

    bit   [STAMP_W-1:0]   vertex_stamp [MAX_VERTICES_DEF];
    bit   [STAMP_W-1:0]   now_stamp;
    logic [FACE_BITS-1:0] face_ctr;
    logic [CFG_BITS-1:0]  cache_reg;
    t_face_verdict        verdict_q [$];
    int                   err_count;

    assign o_errors = err_count;

    function automatic logic [STAMP_W-1:0] clamped_cache();
        if (cache_reg < 1)
            return STAMP_W'(1);
        if (cache_reg > MAX_CACHE_DEF)
            return STAMP_W'(MAX_CACHE_DEF);
        return STAMP_W'(cache_reg);
    endfunction

    // A vertex misses when it was stamped more than the cache size ago.
    function automatic bit probe_vertex(input logic [VERT_BITS-1:0] idx,
                                        input logic [STAMP_W-1:0] limit);
        logic [STAMP_W-1:0] age;
        age = now_stamp - vertex_stamp[idx];
        if (age > limit) begin
            vertex_stamp[idx] = now_stamp;
            now_stamp = now_stamp + 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_face_verdict simulate_triangle(
            input logic [S_TDATA_BITS-1:0] verts, input logic fresh_run);
        t_face_verdict      res;
        logic [STAMP_W-1:0] cs;
        int                 missed;
        cs = clamped_cache();
        missed = 0;
        if (fresh_run) begin
            // A new mesh pushes every stamp out of the cache window.
            now_stamp = now_stamp + cs + 1'b1;
            face_ctr = '0;
        end
        for (int k = 0; k < VERTS_PER_FACE; k++)
            missed += probe_vertex(verts[k*VERT_BITS +: VERT_BITS], cs);
        res.misses   = MISS_BITS'(missed);
        res.face     = face_ctr;
        res.boundary = (face_ctr == '0) || (missed == VERTS_PER_FACE);
        if (face_ctr != FACE_MAX)
            face_ctr = face_ctr + 1'b1;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] result mismatch on %s: got %0d, expected %0d",
                 $time, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_face_verdict want;
        t_face_verdict predicted;
        if (!i_rst_n) begin
            foreach (vertex_stamp[i])
                vertex_stamp[i] = '0;
            cache_reg = CACHE_RESET;
            now_stamp = clamped_cache() + 1'b1;
            face_ctr  = '0;
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                cache_reg = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                predicted = simulate_triangle(i_s_tdata, i_s_tuser);
                verdict_q.insert(verdict_q.size(), predicted);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch("unexpected result transaction", i_m_tdata, 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_m_tdata[0 +: MISS_BITS] !== want.misses)
                        flag_mismatch("miss_count", i_m_tdata[0 +: MISS_BITS], want.misses);
                    if (i_m_tdata[MISS_BITS +: FACE_BITS] !== want.face)
                        flag_mismatch("face_index", i_m_tdata[MISS_BITS +: FACE_BITS],
                                      want.face);
                    if (i_m_tuser !== want.boundary)
                        flag_mismatch("is_boundary", i_m_tuser, want.boundary);
                    if (i_m_tdata[MISS_BITS+FACE_BITS +: PAD_BITS] !== '0)
                        flag_mismatch("tdata padding",
                                      i_m_tdata[MISS_BITS+FACE_BITS +: PAD_BITS], 0);
                end
            end
        end
        o_outstanding <= verdict_q.size();
    end

endmodule

/* test/tb_vertex_cache_hard_boundaries.sv */
// ----------------------------------------------------------------------------
// tb_vertex_cache_hard_boundaries: testbench of the vertex cache miss simulator
// Sends directed triangles and then mesh-like random triangle streams under
// several cache sizes and idling patterns; a separate checker predicts and
// compares every result transaction.
// ----------------------------------------------------------------------------
module tb_vertex_cache_hard_boundaries;
    import vch_pkg::*;

    // The limit covers the reset sweep over every slot of the stamp memory.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SEG_ITEMS    = 125;
    localparam int TAIL_CYCLES  = 20;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_BITS-1:0]     i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic                    m_axis_tuser;

    int mismatch_total;
    int outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int cycle_count;

    vertex_cache_hard_boundaries dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    vch_face_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_errors      (mismatch_total),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side. A pending hold request turns into a long stretch with
    // tready low, so the block fills up and pushes back on its input.
    initial begin : receiver
        m_axis_tready = 1'b0;
        hold_served = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_served != hold_requests) begin
                hold_left = HOLD_CYCLES;
                hold_served++;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** vertex_cache_hard_boundaries: FAILED **");
        $finish;
    end

    // Offers one triangle and returns at the edge where its transaction happens.
    // tvalid stays high on return, so back-to-back items need no gap.
    task automatic send_triangle(input logic [VERT_BITS-1:0] va, input logic [VERT_BITS-1:0] vb,
                                 input logic [VERT_BITS-1:0] vc, input logic fresh_run);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {vc, vb, va};
        s_axis_tuser  = fresh_run;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    // Only called with the block idle, i.e. after wait_drain or right after reset.
    task automatic write_cache_entries(input logic [CFG_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mesh-like stream: most triangles draw their vertices from a small sliding
    // window, so vertices repeat and hit; a tenth are scattered noise.
    task automatic run_mesh_segment(input int count, input bit with_hold);
        logic [VERT_BITS-1:0] base;
        logic [VERT_BITS-1:0] v [VERTS_PER_FACE];
        int                   span;
        logic                 fresh;
        base = VERT_BITS'($urandom);
        span = $urandom_range(4, 48);
        for (int k = 0; k < count; k++) begin
            fresh = ($urandom_range(99) < 3);
            if (fresh) begin
                base = VERT_BITS'($urandom);
                span = $urandom_range(4, 48);
            end else if ($urandom_range(99) < 30) begin
                base = base + VERT_BITS'($urandom_range(0, 3));
            end
            if ($urandom_range(99) < 10) begin
                foreach (v[j])
                    v[j] = VERT_BITS'($urandom);
            end else begin
                foreach (v[j])
                    v[j] = base + VERT_BITS'($urandom_range(0, span));
                // Degenerate triangles exercise the in-triangle repeat hit.
                if ($urandom_range(99) < 5)
                    v[2] = v[0];
            end
            send_triangle(v[0], v[1], v[2], fresh);
            if (with_hold && k == count / 2)
                hold_requests++;
        end
    endtask

    initial begin : stimulus
        logic [CFG_BITS-1:0] size_plan [9];
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = 0;
        size_plan = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd16, 7'd40, 7'd0};
        size_plan[8] = CFG_BITS'($urandom);

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset cache size first. The very first triangle is a
        // boundary without new_run because its face index is zero.
        send_triangle(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_triangle(16'hFFFF, 16'hFFFE, 16'h8000, 1'b0);
        send_triangle(16'hFFFF, 16'hFFFF, 16'h0001, 1'b0);
        send_triangle(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        send_triangle(16'hAAAA, 16'h5555, 16'hFFFF, 1'b1);
        send_triangle(16'h0000, 16'h0001, 16'h0002, 1'b0);
        send_triangle(16'h0001, 16'h0002, 16'h0003, 1'b0);
        send_triangle(16'h0002, 16'h0003, 16'h0004, 1'b0);
        send_triangle(16'h0000, 16'h0002, 16'h0004, 1'b0);
        // Smallest cache: a vertex is evicted by the very next miss.
        wait_drain();
        write_cache_entries(7'd1);
        send_triangle(16'd10, 16'd11, 16'd12, 1'b0);
        send_triangle(16'd12, 16'd11, 16'd10, 1'b0);
        send_triangle(16'd10, 16'd13, 16'd10, 1'b0);
        send_triangle(16'd10, 16'd11, 16'd12, 1'b1);
        // A written zero acts as a cache of one entry.
        wait_drain();
        write_cache_entries(7'd0);
        send_triangle(16'd20, 16'd21, 16'd20, 1'b0);
        send_triangle(16'd21, 16'd20, 16'd22, 1'b0);
        // All ones clamps to the largest cache.
        wait_drain();
        write_cache_entries(7'd127);
        send_triangle(16'hFFFF, 16'h0000, 16'h8000, 1'b1);
        send_triangle(16'h0000, 16'h8000, 16'hFFFF, 1'b0);
        send_triangle(16'h7FFF, 16'h1234, 16'hEDCB, 1'b0);
        wait_drain();
        write_cache_entries(7'd64);
        send_triangle(16'd1, 16'd2, 16'd3, 1'b0);
        send_triangle(16'd100, 16'd101, 16'd102, 1'b1);

        // Random part in three idling phases, three cache sizes per phase.
        for (int p = 0; p < 3; p++) begin
            wait_drain();
            send_idle_pct = (p == 0) ? 34 : (p == 1) ? 50 : 0;
            recv_idle_pct = (p == 0) ? 50 : (p == 1) ? 34 : 0;
            for (int s = 0; s < 3; s++) begin
                wait_drain();
                write_cache_entries(size_plan[p*3 + s]);
                run_mesh_segment(SEG_ITEMS, (s == 1) && (p != 1));
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_total == 0)
            $display("** vertex_cache_hard_boundaries: PASSED **");
        else
            $display("** vertex_cache_hard_boundaries: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
hdl/vch_pkg.sv
hdl/vch_queue.sv
hdl/vch_front.sv
hdl/vch_back.sv
hdl/vertex_cache_hard_boundaries.sv
hdl/vch_checker.sv
test/vch_face_checker.sv
test/tb_vertex_cache_hard_boundaries.sv
